// ----- src/shah_pkg.sv -----
// Shared types, constants and round constants of the SHA-256 / SHA-224 hasher.
package shah_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD80,
		S_ZERO,
		S_LEN_HI,
		S_LEN_LO,
		S_COMP,
		S_ADD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic iv_load;
		logic iv_224;
		logic comp_start;
		logic round_en;
		logic chain_add;
	} core_ctl_t;

	typedef struct packed {
		logic push;
		logic expand;
	} sched_ctl_t;

	localparam logic [3:0] NW256 = 4'd8;
	localparam logic [3:0] NW224 = 4'd7;
	localparam logic [3:0] LAST_SLOT = 4'd15;
	localparam logic [3:0] LEN_SLOT = 4'd14;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	localparam logic [31:0] IV256 [0:7] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] IV224 [0:7] = '{
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
			6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
			6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
			6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
			6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

// ----- src/sha256_sha224_hash_top.sv -----
// Top level of the streaming SHA-256 / SHA-224 hasher: sequencer, byte packing and output.
//
// Input words carry up to four message bytes (first byte in bits 31:24), a byte count
// (values above four count as four) and a last mark. A word that completes a 64-byte
// block starts a compression (load on the accepting edge, 64 rounds of the single round
// unit, chaining add), and in_ready stays low until the chaining add is done.
// After a word with the last mark the block pads the message: it pushes the 0x80 word,
// zero words up to the length slot and the two length words, then runs a final
// compression (plus one extra block when fewer than nine bytes of room remained). After
// the final chaining add the sequencer enters S_OUT and loads the first digest word.
// The digest then leaves on the output channel, one word per cycle while out_ready is
// high: eight words for SHA-256, seven for SHA-224, word_index counting from 0 and
// last_word on the final one. A stalled receiver simply holds the output register.
// Once the last digest word is taken the initial values are reloaded and in_ready rises.
// The mode register is written over the cfg channel while idle; a write reloads the
// initial values and drops any partial message. Reset selects SHA-256 and an empty
// message.
module sha256_sha224_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        mode_sha224
);
	import shah_pkg::*;

	state_t      state_q;
	state_t      state_d;
	state_t      ret_q;
	state_t      ret_d;
	logic        mode_q;
	logic [63:0] total_q;
	logic [31:0] acc_q;
	logic [3:0]  wcnt_q;
	logic [5:0]  rnd_q;
	logic [3:0]  oidx_q;
	logic        out_valid_q;
	logic [31:0] digest_word_q;
	logic [2:0]  word_index_q;
	logic        last_word_q;

	logic        in_fire;
	logic        cfg_fire;
	logic [2:0]  nbytes;
	logic [1:0]  part;
	logic [31:0] data_masked;
	logic [63:0] packed_bytes;
	logic        word_full;
	logic [31:0] pad_word;
	logic [3:0]  nwords;
	logic        push;
	logic [31:0] push_word;
	logic        out_load;
	logic        finish;
	logic        pad_clear;
	logic [31:0] rd_word;
	logic [31:0] w_word;
	core_ctl_t   core_ctl;
	sched_ctl_t  sched_ctl;

	assign in_fire = in_valid && in_ready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign nbytes = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign part = total_q[1:0];
	assign data_masked = data_word & ~(32'hFFFF_FFFF >> {nbytes, 3'b000});
	// Bytes already held stay in front, the new ones follow right behind them.
	assign packed_bytes = {acc_q, 32'h0} | ({data_masked, 32'h0} >> {part, 3'b000});
	assign word_full = ({1'b0, part} + nbytes) >= 3'd4;
	assign pad_word = acc_q | (32'h8000_0000 >> {part, 3'b000});
	assign nwords = mode_q ? NW224 : NW256;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		push = 1'b0;
		push_word = packed_bytes[63:32];
		core_ctl = '0;
		in_ready = 1'b0;
		cfg_ready = 1'b0;
		out_load = 1'b0;
		finish = 1'b0;
		pad_clear = 1'b0;
		case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				in_ready = !cfg_valid;
				if (cfg_fire) begin
					core_ctl.iv_load = 1'b1;
					core_ctl.iv_224 = mode_sha224;
				end else if (in_fire) begin
					push = word_full;
					if (word_full && wcnt_q == LAST_SLOT) begin
						state_d = S_COMP;
						core_ctl.comp_start = 1'b1;
						ret_d = last_item ? S_PAD80 : S_IDLE;
					end else if (last_item) begin
						state_d = S_PAD80;
					end
				end
			end
			S_PAD80: begin
				push = 1'b1;
				push_word = pad_word;
				pad_clear = 1'b1;
				if (wcnt_q == LAST_SLOT) begin
					state_d = S_COMP;
					core_ctl.comp_start = 1'b1;
					ret_d = S_ZERO;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_ZERO: begin
				push_word = '0;
				if (wcnt_q == LEN_SLOT) begin
					state_d = S_LEN_HI;
				end else begin
					push = 1'b1;
					if (wcnt_q == LAST_SLOT) begin
						state_d = S_COMP;
						core_ctl.comp_start = 1'b1;
						ret_d = S_ZERO;
					end
				end
			end
			S_LEN_HI: begin
				push = 1'b1;
				push_word = total_q[60:29];
				state_d = S_LEN_LO;
			end
			S_LEN_LO: begin
				push = 1'b1;
				push_word = {total_q[28:0], 3'b000};
				state_d = S_COMP;
				core_ctl.comp_start = 1'b1;
				ret_d = S_OUT;
			end
			S_COMP: begin
				core_ctl.round_en = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				core_ctl.chain_add = 1'b1;
				state_d = ret_q;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					if (oidx_q == nwords) begin
						finish = 1'b1;
						core_ctl.iv_load = 1'b1;
						core_ctl.iv_224 = mode_q;
						state_d = S_IDLE;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		sched_ctl.push = push;
		sched_ctl.expand = core_ctl.round_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			mode_q <= 1'b0;
			total_q <= '0;
			acc_q <= '0;
			wcnt_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (cfg_fire) begin
				mode_q <= mode_sha224;
			end
			if (cfg_fire || finish) begin
				total_q <= '0;
				acc_q <= '0;
				wcnt_q <= '0;
			end else begin
				if (in_fire) begin
					total_q <= total_q + 64'(nbytes);
					acc_q <= word_full ? packed_bytes[31:0] : packed_bytes[63:32];
				end else if (pad_clear) begin
					acc_q <= '0;
				end
				if (push) begin
					wcnt_q <= wcnt_q + 4'd1;
				end
			end
			if (core_ctl.comp_start) begin
				rnd_q <= '0;
			end else if (core_ctl.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (core_ctl.chain_add) begin
				oidx_q <= '0;
			end else if (out_load) begin
				oidx_q <= oidx_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_word_q <= rd_word;
			word_index_q <= oidx_q[2:0];
			last_word_q <= (oidx_q == (nwords - 4'd1));
		end
	end

	shah_sched u_sched (
		.clk      (clk),
		.ctl      (sched_ctl),
		.ext_word (push_word),
		.w_word   (w_word)
	);

	shah_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (core_ctl),
		.k_word  (round_k(rnd_q)),
		.w_word  (w_word),
		.rd_idx  (oidx_q[2:0]),
		.rd_word (rd_word)
	);

	assign out_valid = out_valid_q;
	assign digest_word = digest_word_q;
	assign word_index = word_index_q;
	assign last_word = last_word_q;

	// Input is never taken while digest words are still being handed out.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while digest output pending");

	// Taking the final digest word returns the block to idle at once.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (state_q == S_IDLE))
		else $error("block not idle after final digest word");

	// The length words always close a block exactly.
	a_final_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN_LO) |-> (wcnt_q == LAST_SLOT))
		else $error("length words misaligned in final block");

	// SHA-224 never shows a word index beyond six.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!mode_q || word_index != 3'd7))
		else $error("digest word index out of range for mode");

	// A compression always runs from its first round.
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		core_ctl.comp_start |=> (rnd_q == 6'd0 && state_q == S_COMP))
		else $error("compression started at wrong round");

endmodule

// ----- src/shah_sched.sv -----
// Message schedule: a sixteen-word shift line that takes block words and expands them.
module shah_sched (
	input  logic                   clk,
	input  shah_pkg::sched_ctl_t   ctl,
	input  logic [31:0]            ext_word,
	output logic [31:0]            w_word
);
	import shah_pkg::*;

	logic [31:0] w_q [0:15];
	logic [31:0] s0;
	logic [31:0] s1;
	logic [31:0] next_w;
	logic [31:0] in_word;

	// Position k of the line holds W[t+k] while round t runs.
	assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
		^ (w_q[1] >> 3);
	assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign next_w = s1 + w_q[9] + s0 + w_q[0];
	assign in_word = ctl.expand ? next_w : ext_word;
	assign w_word = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.expand) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= in_word;
		end
	end

endmodule

// ----- src/shah_core.sv -----
// Compression core: chaining value, working variables and the shared round unit.
module shah_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  shah_pkg::core_ctl_t   ctl,
	input  logic [31:0]           k_word,
	input  logic [31:0]           w_word,
	input  logic [2:0]            rd_idx,
	output logic [31:0]           rd_word
);
	import shah_pkg::*;

	logic [31:0] chain_q [0:7];
	logic [31:0] wv_q [0:7];
	logic [31:0] big_s0;
	logic [31:0] big_s1;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign big_s1 = {wv_q[4][5:0], wv_q[4][31:6]} ^ {wv_q[4][10:0], wv_q[4][31:11]}
		^ {wv_q[4][24:0], wv_q[4][31:25]};
	assign big_s0 = {wv_q[0][1:0], wv_q[0][31:2]} ^ {wv_q[0][12:0], wv_q[0][31:13]}
		^ {wv_q[0][21:0], wv_q[0][31:22]};
	assign ch = wv_q[6] ^ (wv_q[4] & (wv_q[5] ^ wv_q[6]));
	assign maj = (wv_q[0] & wv_q[1]) | (wv_q[2] & (wv_q[0] | wv_q[1]));
	assign t1 = wv_q[7] + big_s1 + ch + k_word + w_word;
	assign t2 = big_s0 + maj;
	assign rd_word = chain_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV256[i];
			end
		end else if (ctl.iv_load) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= ctl.iv_224 ? IV224[i] : IV256[i];
			end
		end else if (ctl.chain_add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + wv_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.comp_start) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (ctl.round_en) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

endmodule

// ----- test/sha256_digest_checker.sv -----
// Checker for the SHA-256 / SHA-224 hasher: tracks the hash state and compares digest words.
`timescale 1ns / 1ps

module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        mode_sha224,
	output int          pending_words,
	output int          fail_count
);

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  pos;
		logic        tail;
	} digest_exp_t;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] INIT_256 [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] INIT_224 [8] = '{
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
	};

	logic        mode_224;
	logic [31:0] chain_h [8];
	logic [7:0]  msg_block [64];
	logic [63:0] msg_bytes;
	digest_exp_t digest_q [$];

	initial begin
		pending_words = 0;
		fail_count = 0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic start_message();
		int i;
		for (i = 0; i < 8; i++)
			chain_h[i] = mode_224 ? INIT_224[i] : INIT_256[i];
		msg_bytes = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, s0, s1;
		int t;
		for (t = 0; t < 8; t++)
			v[t] = chain_h[t];
		for (t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
				s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
				wt = s1 + w[(t-7)%16] + s0 + w[t%16];
				w[t%16] = wt;
			end
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (t = 0; t < 8; t++)
			chain_h[t] = chain_h[t] + v[t];
	endtask

	// Feeds one input word into the running hash; a final word pads and queues the digest.
	task automatic absorb_word(input logic [31:0] d, input logic [2:0] cnt, input logic fin);
		int i, n, fill, nw;
		logic [63:0] bit_len;
		digest_exp_t e;
		n = (cnt > 3'd4) ? 4 : int'(cnt);
		for (i = 0; i < n; i++) begin
			msg_block[msg_bytes[5:0]] = d[31-8*i -: 8];
			msg_bytes = msg_bytes + 64'd1;
			if (msg_bytes[5:0] == 6'd0)
				compress_block();
		end
		if (!fin)
			return;
		fill = int'(msg_bytes[5:0]);
		msg_block[fill] = 8'h80;
		fill = fill + 1;
		// Fewer than eight bytes left for the length: finish this block and pad a fresh one.
		if (fill > 56) begin
			while (fill < 64) begin
				msg_block[fill] = 8'h00;
				fill = fill + 1;
			end
			compress_block();
			fill = 0;
		end
		while (fill < 56) begin
			msg_block[fill] = 8'h00;
			fill = fill + 1;
		end
		bit_len = msg_bytes << 3;
		for (i = 0; i < 8; i++)
			msg_block[56+i] = bit_len[63-8*i -: 8];
		compress_block();
		nw = mode_224 ? 7 : 8;
		for (i = 0; i < nw; i++) begin
			e.value = chain_h[i];
			e.pos = i[2:0];
			e.tail = (i == nw - 1);
			digest_q.push_back(e);
		end
		start_message();
	endtask

	always @(posedge clk) begin
		digest_exp_t e;
		if (!arst_n) begin
			mode_224 = 1'b0;
			start_message();
			digest_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest word %h index %0d last %b",
							digest_word, word_index, last_word);
				end else begin
					e = digest_q.pop_front();
					if (digest_word !== e.value || word_index !== e.pos || last_word !== e.tail) begin
						fail_count++;
						if (fail_count <= 10)
							$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
								e.value, e.pos, e.tail, digest_word, word_index, last_word);
					end
				end
			end
			// A mode write restarts the message with the new initial values.
			if (cfg_valid && cfg_ready) begin
				mode_224 = mode_sha224;
				start_message();
			end
			if (in_valid && in_ready)
				absorb_word(data_word, byte_count, last_item);
		end
		pending_words = digest_q.size();
	end

endmodule

// ----- test/tb_sha256_sha224_hash_top.sv -----
// Testbench top for the SHA-256 / SHA-224 hasher: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_sha256_sha224_hash_top;

	localparam int SETTLE_CYCLES = 90;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_WORDS = 52;
	localparam int PHASES = 4;
	localparam logic MODE_256 = 1'b0;
	localparam logic MODE_224 = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        mode_sha224 = 1'b0;

	int pending_words;
	int fail_count;
	int cycles = 0;
	int words_sent = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	sha256_sha224_hash_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.mode_sha224 (mode_sha224)
	);

	sha256_digest_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_word     (data_word),
		.byte_count    (byte_count),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.mode_sha224   (mode_sha224),
		.pending_words (pending_words),
		.fail_count    (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** sha256_sha224_hash_top: FAILED **");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver side: hold out_ready low for a random number of cycles between ready cycles.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// Valid is only lowered ahead of a gap, so back-to-back words keep it high.
	task automatic send_word(input logic [31:0] d, input logic [2:0] cnt, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= d;
		byte_count <= cnt;
		last_item <= fin;
		do @(posedge clk); while (!in_ready);
		if (cnt != 3'd0 || fin)
			words_sent++;
	endtask

	// Waits until every digest word has arrived and any block still compressing is done.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		mode_sha224 <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Sends nbytes of random message; sometimes the last mark rides on an empty word.
	task automatic send_message(input int nbytes, input bit fin);
		int left, raw, take;
		bit tail_empty;
		left = nbytes;
		tail_empty = fin && (nbytes == 0 || $urandom_range(0, 3) == 0);
		while (left > 0) begin
			raw = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 7);
			take = (raw > 4) ? 4 : raw;
			if (take > left) begin
				raw = left;
				take = left;
			end
			left = left - take;
			send_word($urandom, raw[2:0], fin && !tail_empty && left == 0);
		end
		if (tail_empty)
			send_word($urandom, 3'd0, 1'b1);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom_range(52, 68);
		if (r == 3)
			return 0;
		return $urandom_range(1, 80);
	endfunction

	initial begin
		int p, phase_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_256);
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_63FF, 3'd3, 1'b1);
		send_word(32'h0000_0000, 3'd0, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
		send_word(32'h1234_5678, 3'd5, 1'b0);
		send_word(32'h9ABC_DEF0, 3'd6, 1'b1);
		send_word(32'hA5A5_A5A5, 3'd4, 1'b0);
		send_word(32'h0000_0000, 3'd0, 1'b1);
		// A partial message that the mode write below must discard.
		send_word(32'hDEAD_BEEF, 3'd4, 1'b0);
		send_word(32'h0102_0304, 3'd2, 1'b0);
		settle();
		write_mode(MODE_224);
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'h8000_0000, 3'd1, 1'b1);

		words_sent = 0;
		for (p = 0; p < PHASES; p++) begin
			settle();
			write_mode((p % 2 == 0) ? MODE_256 : MODE_224);
			calm = ($urandom_range(0, 3) == 0);
			phase_start = words_sent;
			while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
				if ($urandom_range(0, 9) == 0)
					send_word($urandom, 3'd0, 1'b0);
				send_message(pick_length(), 1'b1);
			end
			if ($urandom_range(0, 1) == 1)
				send_message($urandom_range(1, 70), 1'b0);
		end
		calm = 1'b0;
		settle();

		if (fail_count == 0 && pending_words == 0)
			$display("** sha256_sha224_hash_top: PASSED **");
		else
			$display("** sha256_sha224_hash_top: FAILED **");
		$finish;
	end

endmodule

// ----- sha256_sha224_hash_top.f -----
src/shah_pkg.sv
src/shah_sched.sv
src/shah_core.sv
src/sha256_sha224_hash_top.sv
test/sha256_digest_checker.sv
test/tb_sha256_sha224_hash_top.sv
